FILE: rtl/deq_pkg.sv
// Package for the double-ended queue: sizes, command and status codes,
// beat types and the controller-to-datapath control struct. No dependencies.
`default_nettype none

package deq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 17;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int SUM_BITS   = COUNT_BITS + 1;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [VALUE_BITS-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] popped_value;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  is_empty;
        logic [VALUE_BITS-1:0] front_value;
        logic [VALUE_BITS-1:0] back_value;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_POST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic do_op;
        logic load_result;
    } t_dp_ctrl;

endpackage

`default_nettype wire

FILE: rtl/deq_datapath.sv
// Datapath of the double-ended queue: ring memory, head and count registers,
// captured command and result register. Depends on deq_pkg.
`default_nettype none

module deq_datapath
    import deq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_ctrl  i_ctrl,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    logic [VALUE_BITS-1:0] r_ring [CAPACITY];

    logic [2:0]            r_cmd;
    logic [VALUE_BITS-1:0] r_push_value;
    logic [ADDR_BITS-1:0]  r_head, n_head;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [VALUE_BITS-1:0] r_rd_front, r_rd_back;
    logic [VALUE_BITS-1:0] r_popped, n_popped;
    logic [1:0]            r_status, n_status;
    t_out_item             r_result;

    logic [ADDR_BITS-1:0]  w_tail, w_slot_end, w_head_dec, w_head_inc, w_wr_addr;
    logic [SUM_BITS-1:0]   w_sum_end, w_sum_tail;
    logic                  w_wr_en, w_full, w_empty;

    function automatic logic [ADDR_BITS-1:0] wrap(input logic [SUM_BITS-1:0] sum);
        logic [SUM_BITS-1:0] cap;
        cap = SUM_BITS'(CAPACITY);
        if (sum >= cap) begin
            wrap = ADDR_BITS'(sum - cap);
        end else begin
            wrap = ADDR_BITS'(sum);
        end
    endfunction

    assign w_full  = (r_count == COUNT_BITS'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_sum_end  = SUM_BITS'(r_head) + SUM_BITS'(r_count);
    assign w_sum_tail = w_empty ? SUM_BITS'(r_head) : w_sum_end - SUM_BITS'(1);
    assign w_slot_end = wrap(w_sum_end);
    assign w_tail     = wrap(w_sum_tail);
    assign w_head_dec = (r_head == '0) ? ADDR_BITS'(CAPACITY - 1) : r_head - ADDR_BITS'(1);
    assign w_head_inc = (r_head == ADDR_BITS'(CAPACITY - 1)) ? '0 : r_head + ADDR_BITS'(1);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_popped  = '0;
        n_status  = STATUS_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = w_slot_end;
        case (r_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_count = r_count + COUNT_BITS'(1);
                    if (r_cmd == CMD_PUSH_FRONT) begin
                        w_wr_addr = w_head_dec;
                        n_head    = w_head_dec;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_count = r_count - COUNT_BITS'(1);
                    if (r_cmd == CMD_POP_FRONT) begin
                        n_popped = r_rd_front;
                        n_head   = w_head_inc;
                    end else begin
                        n_popped = r_rd_back;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // reads run every cycle at the current pointers; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_ctrl.do_op && w_wr_en) begin
            r_ring[w_wr_addr] <= r_push_value;
        end
        r_rd_front <= r_ring[r_head];
        r_rd_back  <= r_ring[w_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctrl.do_op) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) begin
            r_cmd        <= i_item.cmd;
            r_push_value <= i_item.push_value;
        end
        if (i_ctrl.do_op) begin
            r_popped <= n_popped;
            r_status <= n_status;
        end
        if (i_ctrl.load_result) begin
            r_result.popped_value <= r_popped;
            r_result.status       <= r_status;
            r_result.entry_count  <= r_count;
            r_result.is_empty     <= w_empty;
            r_result.front_value  <= w_empty ? '0 : r_rd_front;
            r_result.back_value   <= w_empty ? '0 : r_rd_back;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/deq_controller.sv
// Controller of the double-ended queue: sequences accept, update, re-read
// and result load, and owns both handshakes. Depends on deq_pkg.
`default_nettype none

module deq_controller
    import deq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_dp_ctrl  o_ctrl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state            = r_state;
        n_out_valid        = r_out_valid && i_out_stall;
        o_ctrl             = '0;
        o_in_stall         = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load_item = 1'b1;
                    n_state          = ST_OP;
                end
            end
            ST_OP: begin
                o_ctrl.do_op = 1'b1;
                n_state      = ST_POST;
            end
            ST_POST: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctrl.load_result = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Top level of the double-ended queue: joins controller and datapath.
// Depends on deq_pkg, deq_controller and deq_datapath.
//
// Each input beat carries one command (push front, push back, pop front, pop back,
// query; unused codes act as query) and yields one result beat with the popped
// value, status, and count, empty flag, front and back after the command. Each
// item passes accept, update, re-read and result load in turn; the re-read is due
// to the registered read of the ring memory, needed once before and once after the
// pointer update. The result sits in an output register, so the next item is
// accepted while a result still waits. No clearing pass after reset.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    t_dp_ctrl w_ctrl;

    deq_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctrl      (w_ctrl)
    );

    deq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_item   (i_in_item),
        .o_result (o_out_item)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.entry_count <= COUNT_BITS'(CAPACITY)))
        else $error("entry count above capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_empty == (o_out_item.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == STATUS_FULL)
            |-> (o_out_item.entry_count == COUNT_BITS'(CAPACITY)))
        else $error("full status while not full");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat accepted during an item");

endmodule

`default_nettype wire

FILE: test/double_ended_queue_tb.sv
// Self-checking testbench for double_ended_queue: a scripted warm-up, then random
// commands under several valid/stall patterns, each result beat compared with a
// behavioral deque kept in the bench. Depends on deq_pkg and the RTL only.
`timescale 1ns / 1ps

module double_ended_queue_tb;
    import deq_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam logic [VALUE_BITS-1:0] VAL_MAX = '1;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int SCRIPT_ROWS  = 24;
    localparam int PEND_DEPTH   = 8;
    localparam int FILL_LIMIT   = 1500;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item want;
    } t_script_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    logic [VALUE_BITS-1:0] shadow_ring [CAPACITY];
    int unsigned shadow_head = 0;
    int unsigned shadow_count = 0;

    t_out_item   pending_results [PEND_DEPTH];
    int          pend_wr = 0;
    int          pend_rd = 0;
    t_script_row script [SCRIPT_ROWS];
    int          script_len = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int beats_sent     = 0;
    int beats_checked  = 0;
    int full_hits      = 0;
    int empty_hits     = 0;
    int idle_cycles    = 0;
    int fill_beats     = 0;

    double_ended_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #4 clk = ~clk;

    function automatic t_out_item res(input logic [VALUE_BITS-1:0] popped,
                                      input logic [1:0] st,
                                      input int cnt,
                                      input int empty,
                                      input logic [VALUE_BITS-1:0] front,
                                      input logic [VALUE_BITS-1:0] back);
        t_out_item r;
        r.popped_value = popped;
        r.status       = st;
        r.entry_count  = COUNT_BITS'(cnt);
        r.is_empty     = (empty != 0);
        r.front_value  = front;
        r.back_value   = back;
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] cmd, input logic [VALUE_BITS-1:0] value,
                                    input int fixed, input t_out_item want);
        t_script_row row;
        row.item.cmd        = cmd;
        row.item.push_value = value;
        row.fixed           = (fixed != 0);
        row.want            = want;
        script[script_len]  = row;
        script_len++;
    endfunction

    // Applies one command to the shadow deque and returns the result it should give.
    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item r;
        r = '0;
        r.status = STATUS_OK;
        case (it.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = STATUS_FULL;
                    full_hits++;
                end else if (it.cmd == CMD_PUSH_FRONT) begin
                    shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
                    shadow_ring[shadow_head] = it.push_value;
                    shadow_count++;
                end else begin
                    shadow_ring[(shadow_head + shadow_count) % CAPACITY] = it.push_value;
                    shadow_count++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = STATUS_EMPTY;
                    empty_hits++;
                end else if (it.cmd == CMD_POP_FRONT) begin
                    r.popped_value = shadow_ring[shadow_head];
                    shadow_head = (shadow_head + 1) % CAPACITY;
                    shadow_count--;
                end else begin
                    r.popped_value = shadow_ring[(shadow_head + shadow_count - 1) % CAPACITY];
                    shadow_count--;
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_BITS'(shadow_count);
        r.is_empty    = (shadow_count == 0);
        if (shadow_count != 0) begin
            r.front_value = shadow_ring[shadow_head];
            r.back_value  = shadow_ring[(shadow_head + shadow_count - 1) % CAPACITY];
        end
        return r;
    endfunction

    function automatic t_in_item random_command(input int push_pct, input int pop_pct);
        t_in_item it;
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            it.cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            it.cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else
            it.cmd = 3'($urandom_range(7));
        case ($urandom_range(7))
            0:       it.push_value = '0;
            1:       it.push_value = VAL_MAX;
            default: it.push_value = VALUE_BITS'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_beat(input t_in_item it, input bit fixed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        predicted = apply_command(it);
        pending_results[pend_wr % PEND_DEPTH] = fixed ? want : predicted;
        pend_wr++;
        beats_sent++;
    endtask

    task automatic check_field(input int idx, input string label,
                               input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: result %0d %s expected 0x%0h actual 0x%0h",
                     $time, idx, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pend_rd == pend_wr) begin
                $display("%0t: unexpected result beat, actual 0x%0h", $time, out_item);
                fail_count++;
            end else begin
                want = pending_results[pend_rd % PEND_DEPTH];
                pend_rd++;
                check_field(beats_checked, "popped_value", want.popped_value,
                            out_item.popped_value);
                check_field(beats_checked, "status", want.status, out_item.status);
                check_field(beats_checked, "entry_count", want.entry_count,
                            out_item.entry_count);
                check_field(beats_checked, "is_empty", want.is_empty, out_item.is_empty);
                check_field(beats_checked, "front_value", want.front_value,
                            out_item.front_value);
                check_field(beats_checked, "back_value", want.back_value,
                            out_item.back_value);
            end
            beats_checked++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;

        add_row(CMD_QUERY,      '0,        1, res('0, STATUS_OK, 0, 1, '0, '0));
        add_row(CMD_POP_FRONT,  '0,        1, res('0, STATUS_EMPTY, 0, 1, '0, '0));
        add_row(CMD_POP_BACK,   VAL_MAX,   1, res('0, STATUS_EMPTY, 0, 1, '0, '0));
        add_row(CMD_SPARE_LO,   VAL_MAX,   1, res('0, STATUS_OK, 0, 1, '0, '0));
        add_row(CMD_PUSH_FRONT, VAL_MAX,   1, res('0, STATUS_OK, 1, 0, VAL_MAX, VAL_MAX));
        add_row(CMD_PUSH_BACK,  '0,        1, res('0, STATUS_OK, 2, 0, VAL_MAX, '0));
        add_row(CMD_PUSH_FRONT, 17'h15555, 1, res('0, STATUS_OK, 3, 0, 17'h15555, '0));
        add_row(CMD_PUSH_BACK,  17'h0aaaa, 1, res('0, STATUS_OK, 4, 0, 17'h15555, 17'h0aaaa));
        add_row(CMD_SPARE_MID,  17'h12345, 1, res('0, STATUS_OK, 4, 0, 17'h15555, 17'h0aaaa));
        add_row(CMD_SPARE_HI,   VAL_MAX,   1, res('0, STATUS_OK, 4, 0, 17'h15555, 17'h0aaaa));
        add_row(CMD_QUERY,      VAL_MAX,   1, res('0, STATUS_OK, 4, 0, 17'h15555, 17'h0aaaa));
        add_row(CMD_POP_BACK,   '0,        1, res(17'h0aaaa, STATUS_OK, 3, 0, 17'h15555, '0));
        add_row(CMD_POP_FRONT,  '0,        1, res(17'h15555, STATUS_OK, 2, 0, VAL_MAX, '0));
        add_row(CMD_POP_FRONT,  '0,        1, res(VAL_MAX, STATUS_OK, 1, 0, '0, '0));
        add_row(CMD_POP_BACK,   '0,        1, res('0, STATUS_OK, 0, 1, '0, '0));
        add_row(CMD_POP_BACK,   '0,        1, res('0, STATUS_EMPTY, 0, 1, '0, '0));
        add_row(CMD_PUSH_BACK,  17'h00001, 1, res('0, STATUS_OK, 1, 0, 17'h00001, 17'h00001));
        add_row(CMD_POP_FRONT,  '0,        1, res(17'h00001, STATUS_OK, 0, 1, '0, '0));
        add_row(CMD_PUSH_FRONT, 17'h10000, 0, '0);
        add_row(CMD_PUSH_BACK,  17'h0ffff, 0, '0);
        add_row(CMD_PUSH_FRONT, 17'h0f0f0, 0, '0);
        add_row(CMD_SPARE_LO,   '0,        0, '0);
        add_row(CMD_POP_BACK,   '0,        0, '0);
        add_row(CMD_POP_FRONT,  '0,        0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < script_len; i++)
            send_beat(script[i].item, script[i].fixed, script[i].want);

        // back to back, filling up
        repeat (500) send_beat(random_command(99, 0), 1'b0, '0);

        // sparse sender, fill until full pushes get rejected a few times
        send_idle_pct = 83;
        while (full_hits < 4 && fill_beats < FILL_LIMIT) begin
            send_beat(random_command(99, 0), 1'b0, '0);
            fill_beats++;
        end

        // slow receiver, churn at the full mark
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        repeat (30) send_beat(random_command(45, 45), 1'b0, '0);

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        repeat (20) send_beat(random_command(20, 70), 1'b0, '0);

        in_valid <= 1'b0;
        while (pend_rd != pend_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands and checked %0d results across four idle/stall mixes.",
                 beats_sent, beats_checked);
        $display("Pushes refused at full: %0d, pops refused on empty: %0d.",
                 full_hits, empty_hits);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
